// ----- rtl/edmk_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Edmonds-Karp max flow package
// Shared types, codes and handshake structs for the max flow core.
// ---------------------------------------------------------------------------
package edmk_pkg;

  localparam int VERTEX_BITS   = 4;
  localparam int ECAP_BITS     = 16;
  localparam int TOTAL_BITS    = 20;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 5;

  localparam logic [1:0] MODE_ADD     = 2'd0;
  localparam logic [1:0] MODE_COMPUTE = 2'd1;
  localparam logic [1:0] MODE_CLEAR   = 2'd2;
  localparam logic [1:0] MODE_SPARE   = 2'd3;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_SAT   = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_VERTEX_COUNT  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SOURCE_VERTEX = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SINK_VERTEX   = 2'd2;

  typedef struct packed {
    logic [1:0]             mode;
    logic [VERTEX_BITS-1:0] from_vertex;
    logic [VERTEX_BITS-1:0] to_vertex;
    logic [ECAP_BITS-1:0]   edge_capacity;
  } item_t;

  typedef struct packed {
    logic [TOTAL_BITS-1:0] flow_total;
    logic [1:0]            status;
  } result_t;

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE, ST_DECODE, ST_ADD_RD, ST_ADD_WR, ST_SWEEP,
    ST_BFS_INIT, ST_POP, ST_POPD, ST_SCAN_RD, ST_SCAN_EV,
    ST_WALK_P, ST_WALK_E, ST_WALK_U, ST_AP_P, ST_AP_F, ST_AP_W1, ST_AP_W2,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic latch_item;
    logic sweep;
    logic sweep_cap;
    logic sweep_flow;
    logic add_rd;
    logic add_wr;
    logic bfs_init;
    logic pop_rd;
    logic pop_load;
    logic scan_rd;
    logic scan_ev;
    logic walk_init;
    logic walk_par;
    logic walk_edge;
    logic walk_upd;
    logic ap_init;
    logic ap_par;
    logic ap_flow;
    logic ap_w1;
    logic ap_w2;
    logic sum_add;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       item_bad;
    logic       cfg_bad;
    logic       src_eq_snk;
    logic       sweep_last;
    logic       q_empty;
    logic       u_is_snk;
    logic       scan_last;
    logic       v_is_src;
    logic       found;
    logic       out_busy;
  } sts_t;

endpackage

// ----- rtl/edmk_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module edmk_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/edmk_ctrl.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Max flow controller
// Sequences loads, clearing passes, searches and augmentations.
// ---------------------------------------------------------------------------
module edmk_ctrl
  import edmk_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_INIT: begin
        cmd_o.sweep      = 1'b1;
        cmd_o.sweep_cap  = 1'b1;
        cmd_o.sweep_flow = 1'b1;
        if (sts_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_item = 1'b1;
          state_d          = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (sts_i.mode)
          MODE_ADD:     state_d = sts_i.item_bad ? ST_DONE : ST_ADD_RD;
          MODE_COMPUTE: state_d = (sts_i.cfg_bad || sts_i.src_eq_snk) ? ST_DONE : ST_SWEEP;
          MODE_CLEAR:   state_d = ST_SWEEP;
          default:      state_d = ST_DONE;
        endcase
      end
      ST_ADD_RD: begin
        cmd_o.add_rd = 1'b1;
        state_d      = ST_ADD_WR;
      end
      ST_ADD_WR: begin
        cmd_o.add_wr = 1'b1;
        state_d      = ST_DONE;
      end
      ST_SWEEP: begin
        cmd_o.sweep      = 1'b1;
        cmd_o.sweep_cap  = (sts_i.mode == MODE_CLEAR);
        cmd_o.sweep_flow = (sts_i.mode == MODE_COMPUTE);
        if (sts_i.sweep_last) begin
          state_d = (sts_i.mode == MODE_COMPUTE) ? ST_BFS_INIT : ST_DONE;
        end
      end
      ST_BFS_INIT: begin
        cmd_o.bfs_init = 1'b1;
        state_d        = ST_POP;
      end
      ST_POP: begin
        if (sts_i.q_empty) begin
          if (sts_i.found) begin
            cmd_o.walk_init = 1'b1;
            state_d         = ST_WALK_P;
          end else begin
            state_d = ST_DONE;
          end
        end else begin
          cmd_o.pop_rd = 1'b1;
          state_d      = ST_POPD;
        end
      end
      ST_POPD: begin
        if (sts_i.u_is_snk) begin
          // The sink is reached, so the path exists.
          cmd_o.walk_init = 1'b1;
          state_d         = ST_WALK_P;
        end else begin
          cmd_o.pop_load = 1'b1;
          state_d        = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        cmd_o.scan_rd = 1'b1;
        state_d       = ST_SCAN_EV;
      end
      ST_SCAN_EV: begin
        cmd_o.scan_ev = 1'b1;
        state_d       = sts_i.scan_last ? ST_POP : ST_SCAN_RD;
      end
      ST_WALK_P: begin
        if (sts_i.v_is_src) begin
          cmd_o.ap_init = 1'b1;
          state_d       = ST_AP_P;
        end else begin
          cmd_o.walk_par = 1'b1;
          state_d        = ST_WALK_E;
        end
      end
      ST_WALK_E: begin
        cmd_o.walk_edge = 1'b1;
        state_d         = ST_WALK_U;
      end
      ST_WALK_U: begin
        cmd_o.walk_upd = 1'b1;
        state_d        = ST_WALK_P;
      end
      ST_AP_P: begin
        if (sts_i.v_is_src) begin
          cmd_o.sum_add = 1'b1;
          state_d       = ST_BFS_INIT;
        end else begin
          cmd_o.ap_par = 1'b1;
          state_d      = ST_AP_F;
        end
      end
      ST_AP_F: begin
        cmd_o.ap_flow = 1'b1;
        state_d       = ST_AP_W1;
      end
      ST_AP_W1: begin
        cmd_o.ap_w1 = 1'b1;
        state_d     = ST_AP_W2;
      end
      ST_AP_W2: begin
        cmd_o.ap_w2 = 1'b1;
        state_d     = ST_AP_P;
      end
      ST_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_INIT;
    endcase
  end

endmodule

// ----- rtl/edmk_dp.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Max flow datapath
// Capacity and flow memories, search queue, parents and result register.
// ---------------------------------------------------------------------------
module edmk_dp
  import edmk_pkg::*;
#(
  parameter int MAX_VERTICES = 16,
  parameter int CAP_BITS     = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  input  item_t                    in_data_i,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output result_t                  out_data_o,
  input  cmd_t                     cmd_i,
  output sts_t                     sts_o
);

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int AW  = 2 * VW;
  localparam int NW  = $clog2(MAX_VERTICES + 1);
  localparam int FW  = CAP_BITS + 1;
  localparam int RW  = CAP_BITS + 2;
  localparam int SW  = ((CAP_BITS > ECAP_BITS) ? CAP_BITS : ECAP_BITS) + 1;
  localparam logic [CAP_BITS-1:0] CapMax = {CAP_BITS{1'b1}};

  item_t                    item_q;
  logic [CFG_DATA_BITS-1:0] vc_q;
  logic [VERTEX_BITS-1:0]   src_q, snk_q;
  logic [AW-1:0]            sweep_q;
  logic [MAX_VERTICES-1:0]  visited_q;
  logic [VW:0]              head_q, tail_q;
  logic [VW-1:0]            u_q, v_q;
  logic [FW-1:0]            neck_q;
  logic [TOTAL_BITS-1:0]    sum_q;
  logic                     sat_q;
  logic                     out_valid_q;
  result_t                  out_q;
  result_t                  out_d;

  logic [NW-1:0]       n_eff;
  logic [VW-1:0]       from_v, to_v, src_v, snk_v;
  logic [CAP_BITS-1:0] cap_rd;
  logic signed [FW-1:0] flow_rd;
  logic [VW-1:0]       par_rd, q_rd;
  logic signed [RW-1:0] res;
  logic                res_pos, hit;
  logic [SW-1:0]       add_sum;
  logic                add_sat;
  logic                tail_room;
  logic                item_bad, cfg_bad;

  logic                cap_we, flow_we, par_we, q_we;
  logic [AW-1:0]       cap_waddr, cap_raddr, flow_waddr, flow_raddr;
  logic [CAP_BITS-1:0] cap_wdata;
  logic [FW-1:0]       flow_wdata;
  logic [VW-1:0]       q_waddr, q_wdata;

  always_comb begin
    if (vc_q < CFG_DATA_BITS'(2)) begin
      n_eff = NW'(2);
    end else if (32'(vc_q) > MAX_VERTICES) begin
      n_eff = NW'(MAX_VERTICES);
    end else begin
      n_eff = NW'(vc_q);
    end
  end

  assign from_v = VW'(item_q.from_vertex);
  assign to_v   = VW'(item_q.to_vertex);
  assign src_v  = VW'(src_q);
  assign snk_v  = VW'(snk_q);

  assign item_bad = (32'(item_q.from_vertex) >= 32'(n_eff)) ||
                    (32'(item_q.to_vertex) >= 32'(n_eff));
  assign cfg_bad  = (32'(src_q) >= 32'(n_eff)) || (32'(snk_q) >= 32'(n_eff));

  assign res       = $signed({2'b00, cap_rd}) - RW'(flow_rd);
  assign res_pos   = !res[RW-1] && (res != '0);
  assign hit       = !visited_q[v_q] && res_pos;
  assign tail_room = tail_q < (VW + 1)'(MAX_VERTICES);
  assign add_sum   = SW'(cap_rd) + SW'(item_q.edge_capacity);
  assign add_sat   = add_sum > SW'(CapMax);

  // Memory port selection.
  always_comb begin
    cap_raddr = {u_q, v_q};
    if (cmd_i.add_rd) cap_raddr = {from_v, to_v};
    if (cmd_i.walk_edge) cap_raddr = {par_rd, v_q};

    flow_raddr = {u_q, v_q};
    if (cmd_i.walk_edge || cmd_i.ap_flow) flow_raddr = {par_rd, v_q};
    if (cmd_i.ap_w1) flow_raddr = {v_q, u_q};

    cap_we    = (cmd_i.sweep && cmd_i.sweep_cap) || cmd_i.add_wr;
    cap_waddr = cmd_i.sweep ? sweep_q : {from_v, to_v};
    cap_wdata = cmd_i.sweep ? '0 : (add_sat ? CapMax : CAP_BITS'(add_sum));

    flow_we    = (cmd_i.sweep && cmd_i.sweep_flow) || cmd_i.ap_w1 || cmd_i.ap_w2;
    flow_waddr = sweep_q;
    flow_wdata = '0;
    if (cmd_i.ap_w1) begin
      flow_waddr = {u_q, v_q};
      flow_wdata = flow_rd + $signed(neck_q);
    end else if (cmd_i.ap_w2) begin
      flow_waddr = {v_q, u_q};
      flow_wdata = flow_rd - $signed(neck_q);
    end

    par_we  = cmd_i.scan_ev && hit;
    q_we    = cmd_i.bfs_init || (cmd_i.scan_ev && hit && tail_room);
    q_waddr = cmd_i.bfs_init ? '0 : tail_q[VW-1:0];
    q_wdata = cmd_i.bfs_init ? src_v : v_q;
  end

  // Result of the current item.
  always_comb begin
    out_d.flow_total = '0;
    out_d.status     = STATUS_OK;
    case (item_q.mode)
      MODE_ADD: begin
        if (item_bad) out_d.status = STATUS_RANGE;
        else if (sat_q) out_d.status = STATUS_SAT;
      end
      MODE_COMPUTE: begin
        if (cfg_bad) out_d.status = STATUS_RANGE;
        else out_d.flow_total = sum_q;
      end
      default: ;
    endcase
  end

  edmk_ram #(.WIDTH(CAP_BITS), .DEPTH(2 ** AW)) u_cap_ram (
    .clk_i   (clk_i),
    .we_i    (cap_we),
    .waddr_i (cap_waddr),
    .wdata_i (cap_wdata),
    .raddr_i (cap_raddr),
    .rdata_o (cap_rd)
  );

  edmk_ram #(.WIDTH(FW), .DEPTH(2 ** AW)) u_flow_ram (
    .clk_i   (clk_i),
    .we_i    (flow_we),
    .waddr_i (flow_waddr),
    .wdata_i (flow_wdata),
    .raddr_i (flow_raddr),
    .rdata_o (flow_rd)
  );

  edmk_ram #(.WIDTH(VW), .DEPTH(2 ** VW)) u_par_ram (
    .clk_i   (clk_i),
    .we_i    (par_we),
    .waddr_i (v_q),
    .wdata_i (u_q),
    .raddr_i (v_q),
    .rdata_o (par_rd)
  );

  edmk_ram #(.WIDTH(VW), .DEPTH(2 ** VW)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (head_q[VW-1:0]),
    .rdata_o (q_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q        <= CFG_DATA_BITS'(16);
      src_q       <= '0;
      snk_q       <= VERTEX_BITS'(15);
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_VERTEX_COUNT:  vc_q  <= cfg_wdata_i;
          CFG_SOURCE_VERTEX: src_q <= cfg_wdata_i[VERTEX_BITS-1:0];
          CFG_SINK_VERTEX:   snk_q <= cfg_wdata_i[VERTEX_BITS-1:0];
          default: ;
        endcase
      end
      if (cmd_i.latch_item) begin
        sweep_q <= '0;
      end else if (cmd_i.sweep) begin
        sweep_q <= sweep_q + AW'(1);
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_item) begin
      item_q <= in_data_i;
      sum_q  <= '0;
      sat_q  <= 1'b0;
    end
    if (cmd_i.add_wr) sat_q <= add_sat;
    if (cmd_i.bfs_init) begin
      visited_q <= MAX_VERTICES'(1) << src_v;
      head_q    <= '0;
      tail_q    <= (VW + 1)'(1);
    end
    if (cmd_i.pop_rd) head_q <= head_q + (VW + 1)'(1);
    if (cmd_i.pop_load) begin
      u_q <= q_rd;
      v_q <= '0;
    end
    if (cmd_i.scan_ev) begin
      if (hit) begin
        visited_q[v_q] <= 1'b1;
        if (tail_room) tail_q <= tail_q + (VW + 1)'(1);
      end
      v_q <= v_q + VW'(1);
    end
    if (cmd_i.walk_init) begin
      v_q    <= snk_v;
      neck_q <= '1;
    end
    if (cmd_i.walk_edge || cmd_i.ap_flow) u_q <= par_rd;
    if (cmd_i.walk_upd) begin
      if (FW'(res) < neck_q) neck_q <= FW'(res);
      v_q <= u_q;
    end
    if (cmd_i.ap_init) v_q <= snk_v;
    if (cmd_i.ap_w2) v_q <= u_q;
    if (cmd_i.sum_add) sum_q <= sum_q + TOTAL_BITS'(neck_q);
    if (cmd_i.load_out) out_q <= out_d;
  end

  assign sts_o.mode       = item_q.mode;
  assign sts_o.item_bad   = item_bad;
  assign sts_o.cfg_bad    = cfg_bad;
  assign sts_o.src_eq_snk = (src_q == snk_q);
  assign sts_o.sweep_last = &sweep_q;
  assign sts_o.q_empty    = (head_q == tail_q);
  assign sts_o.u_is_snk   = (q_rd == snk_v);
  assign sts_o.scan_last  = (v_q == VW'(n_eff - NW'(1)));
  assign sts_o.v_is_src   = (v_q == src_v);
  assign sts_o.found      = visited_q[snk_v];
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/max_flow_edmonds_karp_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Edmonds-Karp max flow core
// Loads a capacity graph edge by edge and computes its maximum flow.
// ---------------------------------------------------------------------------
// One item is worked at a time. After reset a clearing pass over the
// capacity and flow memories runs before the first item is taken. An
// add-edge item reads, adds to and writes back its capacity entry before
// it gives its result. A clear item clears the capacity memory, one entry
// per cycle, before it gives its result. A compute item first clears the
// flow memory in the same way, then runs breadth-first searches: it seeds
// each search, pops and loads each dequeued vertex, reads and evaluates
// each scanned neighbour, and walks each path found once to take the
// bottleneck and once more to update both flow entries of each edge, all
// through single-port reads of the memories. The result register lets a
// new item in while the previous result still waits.
module max_flow_edmonds_karp_core
  import edmk_pkg::*;
#(
  parameter int MAX_VERTICES = 16,
  parameter int CAP_BITS     = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  item_t                    in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output result_t                  out_data_o
);

  cmd_t cmd;
  sts_t sts;

  edmk_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  edmk_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .CAP_BITS     (CAP_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// ----- rtl/edmk_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Max flow port checker
// Port-level properties of the max flow core, bound to the top level.
// ---------------------------------------------------------------------------
module edmk_checker
  import edmk_pkg::*;
(
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_valid_i,
  input logic    in_ready_o,
  input logic    out_valid_o,
  input logic    out_ready_i,
  input result_t out_data_o
);

  // A waiting result item holds its value until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result item changed while stalled");

  // Any error status comes with a zero flow.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != STATUS_OK) |-> out_data_o.flow_total == '0)
    else $error("nonzero flow reported with error status");

  // The core decodes an accepted item before it can take another.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after an accepted item");

  // A result never appears in the cycle right after an item is accepted.
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared without any work");

endmodule

bind max_flow_edmonds_karp_core edmk_checker u_edmk_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ----- verif/max_flow_edmonds_karp_core_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Max flow core testbench
// Drives edge, compute, clear and spare-mode items with random gaps and stalls,
// predicts every result with its own Edmonds-Karp model and checks each result.
// ---------------------------------------------------------------------------

class flow_scoreboard;
  edmk_pkg::result_t pending_q[$];
  int unsigned       mismatches;
  bit [15:0]         cap_m[16][16];
  int                flow_m[16][16];
  bit [4:0]          vcount;
  bit [3:0]          src;
  bit [3:0]          snk;

  function new();
    mismatches = 0;
    vcount     = 5'd16;
    src        = 4'd0;
    snk        = 4'd15;
    foreach (cap_m[i, j]) cap_m[i][j] = '0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [4:0] val);
    if (idx == edmk_pkg::CFG_VERTEX_COUNT) vcount = val;
    else if (idx == edmk_pkg::CFG_SOURCE_VERTEX) src = val[3:0];
    else if (idx == edmk_pkg::CFG_SINK_VERTEX) snk = val[3:0];
  endfunction

  function int unsigned live_vertices();
    if (vcount < 2) return 2;
    if (vcount > 16) return 16;
    return vcount;
  endfunction

  function int unsigned predict_flow(int unsigned n);
    int          parent[16];
    int          fifo[16];
    int          head;
    int          tail;
    int          u;
    int          v;
    int          neck;
    bit [15:0]   seen;
    int unsigned total;
    total = 0;
    foreach (flow_m[i, j]) flow_m[i][j] = 0;
    if (src == snk) return 0;
    forever begin
      head = 0;
      tail = 0;
      seen = 16'd1 << src;
      fifo[tail++] = src;
      while (head < tail) begin
        u = fifo[head++];
        if (u == snk) break;
        for (v = 0; v < n; v++) begin
          if (!seen[v] && int'(cap_m[u][v]) - flow_m[u][v] > 0) begin
            seen[v] = 1'b1;
            parent[v] = u;
            if (tail < 16) fifo[tail++] = v;
          end
        end
      end
      if (!seen[snk]) break;
      neck = -1;
      v = snk;
      while (v != src) begin
        u = parent[v];
        if (neck < 0 || int'(cap_m[u][v]) - flow_m[u][v] < neck)
          neck = int'(cap_m[u][v]) - flow_m[u][v];
        v = u;
      end
      v = snk;
      while (v != src) begin
        u = parent[v];
        flow_m[u][v] += neck;
        flow_m[v][u] -= neck;
        v = u;
      end
      total += neck;
    end
    return total;
  endfunction

  function void note_item(edmk_pkg::item_t it);
    edmk_pkg::result_t r;
    int unsigned       n;
    int unsigned       sum;
    n = live_vertices();
    r = '0;
    if (it.mode == edmk_pkg::MODE_ADD) begin
      if (it.from_vertex >= n || it.to_vertex >= n) begin
        r.status = edmk_pkg::STATUS_RANGE;
      end else begin
        sum = cap_m[it.from_vertex][it.to_vertex] + it.edge_capacity;
        if (sum > 65535) begin
          sum = 65535;
          r.status = edmk_pkg::STATUS_SAT;
        end
        cap_m[it.from_vertex][it.to_vertex] = sum[15:0];
      end
    end else if (it.mode == edmk_pkg::MODE_COMPUTE) begin
      if (src >= n || snk >= n) r.status = edmk_pkg::STATUS_RANGE;
      else r.flow_total = 20'(predict_flow(n));
    end else if (it.mode == edmk_pkg::MODE_CLEAR) begin
      foreach (cap_m[i, j]) cap_m[i][j] = '0;
    end
    pending_q.insert(pending_q.size(), r);
  endfunction

  function void check_result(edmk_pkg::result_t got);
    edmk_pkg::result_t exp_r;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected result flow=%0d status=%0d", $time,
               got.flow_total, got.status);
      mismatches++;
      return;
    end
    exp_r = pending_q.pop_front();
    if (got.flow_total !== exp_r.flow_total) begin
      $display("%0t: flow_total expected %0d actual %0d", $time,
               exp_r.flow_total, got.flow_total);
      mismatches++;
    end
    if (got.status !== exp_r.status) begin
      $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
               got.status);
      mismatches++;
    end
  endfunction
endclass

module max_flow_edmonds_karp_core_tb
  import edmk_pkg::*;
();

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CFG_IDX_BITS-1:0]  cfg_index_i;
  logic [CFG_DATA_BITS-1:0] cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  item_t                    in_data_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  result_t                  out_data_o;

  flow_scoreboard flow_sb;
  int unsigned    cycle_count;
  bit             src_calm;
  bit             sink_calm;
  int unsigned    hold_off;

  max_flow_edmonds_karp_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Cycle limit: a compute on a dense 16-vertex graph can run long, so the
  // cap is wide.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 6000000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: random stalls, a calm stretch, and one long hold-off.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) flow_sb.check_result(out_data_o);
      if (hold_off > 0) begin
        hold_off    <= hold_off - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= sink_calm || ($urandom_range(99) >= 20);
      end
    end
  end

  task automatic send_item(item_t it);
    @(posedge clk_i);
    while (!src_calm && $urandom_range(99) < 20) @(posedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    flow_sb.note_item(it);
    in_valid_i <= 1'b0;
  endtask

  task automatic send_op(logic [1:0] md, int f, int t, int c);
    item_t it;
    it.mode          = md;
    it.from_vertex   = VERTEX_BITS'(f);
    it.to_vertex     = VERTEX_BITS'(t);
    it.edge_capacity = ECAP_BITS'(c);
    send_item(it);
  endtask

  // Registers change only once all results are back and the core is idle.
  task automatic write_reg(logic [1:0] idx, logic [4:0] val);
    while (flow_sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    flow_sb.set_reg(idx, val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_graph(int unsigned edges, int unsigned vmax);
    int     f;
    int     t;
    for (int k = 0; k < edges; k++) begin
      f = $urandom_range(vmax);
      t = $urandom_range(vmax);
      case ($urandom_range(9))
        0: send_op(MODE_ADD, f, t, 16'hFFFF);
        1: send_op(MODE_ADD, $urandom_range(15), $urandom_range(15), $urandom);
        2: send_op(MODE_SPARE, $urandom, $urandom, $urandom);
        default: send_op(MODE_ADD, f, t, $urandom_range(4000));
      endcase
    end
  endtask

  initial begin
    int unsigned sent;
    int unsigned n;
    int unsigned ne;
    bit          held;
    flow_sb     = new();
    cycle_count = 0;
    src_calm    = 1'b0;
    sink_calm   = 1'b0;
    hold_off    = 0;
    held        = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_VERTEX_COUNT;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, starting from the reset settings.
    send_op(MODE_COMPUTE, 0, 0, 0);
    send_op(MODE_ADD, 0, 5, 100);
    send_op(MODE_ADD, 5, 15, 60);
    send_op(MODE_ADD, 0, 15, 16'hFFFF);
    send_op(MODE_ADD, 0, 15, 1);
    send_op(MODE_ADD, 7, 7, 500);
    send_op(MODE_ADD, 15, 0, 0);
    send_op(MODE_SPARE, 15, 15, 16'hFFFF);
    send_op(MODE_COMPUTE, 0, 0, 0);
    write_reg(CFG_VERTEX_COUNT, 5'd6);
    send_op(MODE_ADD, 6, 0, 5);
    send_op(MODE_ADD, 0, 15, 5);
    send_op(MODE_COMPUTE, 0, 0, 0);
    write_reg(CFG_SINK_VERTEX, 5'd5);
    send_op(MODE_COMPUTE, 0, 0, 0);
    write_reg(CFG_SOURCE_VERTEX, 5'd5);
    send_op(MODE_COMPUTE, 0, 0, 0);
    write_reg(CFG_VERTEX_COUNT, 5'd0);
    send_op(MODE_ADD, 1, 0, 9);
    send_op(MODE_COMPUTE, 0, 0, 0);
    write_reg(CFG_VERTEX_COUNT, 5'd31);
    write_reg(CFG_SOURCE_VERTEX, 5'd15);
    write_reg(CFG_SINK_VERTEX, 5'd0);
    send_op(MODE_ADD, 15, 0, 7);
    send_op(MODE_COMPUTE, 0, 0, 0);
    send_op(MODE_CLEAR, 0, 0, 0);
    send_op(MODE_COMPUTE, 0, 0, 0);

    // Random phases: mostly small graphs, a few at full size.
    sent = 20;
    while (sent < 950) begin
      write_reg(CFG_VERTEX_COUNT, ($urandom_range(9) == 0) ? 5'($urandom_range(31))
                                  : 5'($urandom_range(2, 8)));
      n = flow_sb.live_vertices();
      write_reg(CFG_SOURCE_VERTEX, ($urandom_range(9) == 0) ? 5'($urandom_range(15))
                                   : 5'($urandom_range(n - 1)));
      write_reg(CFG_SINK_VERTEX, ($urandom_range(9) == 0) ? 5'($urandom_range(15))
                                 : 5'($urandom_range(n - 1)));
      src_calm  = ($urandom_range(5) == 0);
      sink_calm = ($urandom_range(5) == 0);
      if (!held && sent > 400) begin
        hold_off = 300;
        held     = 1'b1;
      end
      if ($urandom_range(3) != 0) begin
        send_op(MODE_CLEAR, 0, 0, 0);
        sent++;
      end
      for (int r = 0; r < 3; r++) begin
        ne = $urandom_range(2, 3 * n);
        random_graph(ne, n - 1);
        send_op(MODE_COMPUTE, $urandom, $urandom, $urandom);
        sent += ne + 1;
      end
    end

    while (flow_sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (flow_sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ----- files.f -----
rtl/edmk_pkg.sv
rtl/edmk_ram.sv
rtl/edmk_ctrl.sv
rtl/edmk_dp.sv
rtl/max_flow_edmonds_karp_core.sv
rtl/edmk_checker.sv
verif/max_flow_edmonds_karp_core_tb.sv
